FILE: rtl/b2b_pkg.sv
// Shared constants, types and helper functions for the BLAKE2b engine.
`default_nettype none
package b2b_pkg;
  localparam int unsigned Rounds = 12;
  localparam int unsigned RndW = 4;
  localparam logic [63:0] Param0Reset = 64'h0000_0000_0101_0040;

  function automatic logic [63:0] iv(input logic [2:0] i);
    logic [63:0] r;
    unique case (i)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      default: r = 64'h5be0cd19137e2179;
    endcase
    return r;
  endfunction

  // Message schedule: word index for slot j of round r mod 10.
  function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] j);
    logic [63:0] row;
    unique case (r)
      4'd0: row = 64'hfedcba9876543210;
      4'd1: row = 64'h357b20c16df984ae;
      4'd2: row = 64'h491763eadf250c8b;
      4'd3: row = 64'h8f04a562ebcd1397;
      4'd4: row = 64'hd386cb1efa427509;
      4'd5: row = 64'h91ef57d438b0a6c2;
      4'd6: row = 64'hb8293670a4def15c;
      4'd7: row = 64'ha2684f05931ce7bd;
      4'd8: row = 64'h5a417d2c803b9ef6;
      default: row = 64'h0dc3e9bf5167482a;
    endcase
    return row[{j, 2'b00} +: 4];
  endfunction

  typedef struct packed {
    logic load_chain;   // chain from iv ^ params, clear counter
    logic store_word;
    logic add_count;
    logic init_work;
    logic mix_step;     // one half round
    logic diag;         // diagonal half
    logic [RndW-1:0] round;
    logic fold;         // chain ^= v lo ^ v hi
  } b2b_cmd_t;
endpackage
`default_nettype wire

FILE: rtl/blake2b_hash_engine.sv
// Top level of the BLAKE2b-512 hash engine.
`default_nettype none
// Usage: the host streams 64-bit little-endian message words on the s_axis
// channel, sixteen words to a block; tdata carries the word and block_bytes,
// tlast marks block_end and tuser carries message_start and final_block.
// Words are taken only while the engine is idle. On the word with
// block_end the engine stops taking words and runs the compression: it
// sets up the work vector, runs 24 half rounds (one column or diagonal
// half round of four mixers each) and folds the result into the chain.
// After a final block the eight digest words leave on m_axis, index 0
// first, tlast on index 7; input stays stalled until all eight are taken,
// and a stalled receiver simply holds the current word.
// The APB port writes and reads the eight 64-bit parameter-block words at
// byte addresses 8*i; write only while the engine is idle.
// Reset restores the default parameter block (64-byte digest, fanout 1,
// depth 1), clears the counter and returns the controller to idle. Chain
// and block storage are undefined until a message_start word arrives.
module blake2b_hash_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // message_word, block_bytes[7:0]
  input  wire logic [1:0]  s_axis_tuser,  // message_start, final_block
  input  wire logic        s_axis_tlast,  // block_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,  // digest_word, digest_index[2:0], zero pad
  output logic             m_axis_tlast,  // digest_last
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  b2b_pkg::b2b_cmd_t cmd;
  logic [2:0] idx;
  logic [63:0] digest;

  assign pready = 1'b1;

  b2b_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .start_i(s_axis_tuser[0]), .end_i(s_axis_tlast), .fin_i(s_axis_tuser[1]),
    .cmd_o(cmd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_idx_o(idx)
  );

  b2b_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .word_i(s_axis_tdata[63:0]), .bytes_i(s_axis_tdata[71:64]), .fin_i(s_axis_tuser[1]),
    .cfg_we_i(psel && penable && pwrite && pready),
    .cfg_idx_i(paddr[5:3]), .cfg_data_i(pwdata), .cfg_rdata_o(prdata),
    .out_idx_i(idx), .digest_o(digest)
  );

  assign m_axis_tdata = {5'd0, idx, digest};
  assign m_axis_tlast = (idx == 3'd7);
endmodule
`default_nettype wire

FILE: rtl/b2b_datapath.sv
// Datapath: parameter registers, chain, counter, block words, work vector.
`default_nettype none
module b2b_datapath (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire b2b_pkg::b2b_cmd_t cmd_i,
  input  wire logic [63:0] word_i,
  input  wire logic [7:0]  bytes_i,
  input  wire logic        fin_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  output logic [63:0]      cfg_rdata_o,
  input  wire logic [2:0]  out_idx_i,
  output logic [63:0]      digest_o
);
  logic [63:0] param_q [8];
  logic [63:0] chain_q [8];
  logic [63:0] blk_q [16];
  logic [63:0] v_q [16];
  logic [63:0] v_d [16];
  logic [63:0] cnt_lo_q, cnt_hi_q;
  logic [3:0]  pos_q;
  logic        fin_q;
  logic [63:0] sum_lo;

  assign cfg_rdata_o = param_q[cfg_idx_i];
  assign digest_o = chain_q[out_idx_i];
  assign sum_lo = cnt_lo_q + {56'd0, bytes_i};

  function automatic logic [3:0] lane(input logic dg, input logic [1:0] g,
                                      input logic [1:0] k);
    logic [1:0] off;
    off = dg ? (g + k) : g;
    return {k, off};
  endfunction

  always_comb begin
    logic [63:0] a, b, c, d, x, y;
    logic [3:0] ia, ib, ic, id, r10;
    for (int i = 0; i < 16; i++) v_d[i] = v_q[i];
    r10 = (cmd_i.round >= 4'd10) ? cmd_i.round - 4'd10 : cmd_i.round;
    for (int g = 0; g < 4; g++) begin
      ia = lane(cmd_i.diag, 2'(g), 2'd0);
      ib = lane(cmd_i.diag, 2'(g), 2'd1);
      ic = lane(cmd_i.diag, 2'(g), 2'd2);
      id = lane(cmd_i.diag, 2'(g), 2'd3);
      x = blk_q[b2b_pkg::sigma(r10, {cmd_i.diag, 2'(g), 1'b0})];
      y = blk_q[b2b_pkg::sigma(r10, {cmd_i.diag, 2'(g), 1'b1})];
      a = v_q[ia]; b = v_q[ib]; c = v_q[ic]; d = v_q[id];
      a = a + b + x; d = d ^ a; d = {d[31:0], d[63:32]};
      c = c + d; b = b ^ c; b = {b[23:0], b[63:24]};
      a = a + b + y; d = d ^ a; d = {d[15:0], d[63:16]};
      c = c + d; b = b ^ c; b = {b[62:0], b[63]};
      v_d[ia] = a; v_d[ib] = b; v_d[ic] = c; v_d[id] = d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) param_q[i] <= (i == 0) ? b2b_pkg::Param0Reset : '0;
      cnt_lo_q <= '0;
      cnt_hi_q <= '0;
      pos_q <= '0;
      fin_q <= 1'b0;
    end else begin
      if (cfg_we_i) param_q[cfg_idx_i] <= cfg_data_i;
      if (cmd_i.store_word) begin
        if (cmd_i.load_chain) begin
          for (int i = 0; i < 8; i++) chain_q[i] <= b2b_pkg::iv(3'(i)) ^ param_q[i];
          blk_q[0] <= word_i;
          pos_q <= cmd_i.add_count ? 4'd0 : 4'd1;
        end else begin
          blk_q[pos_q] <= word_i;
          pos_q <= cmd_i.add_count ? 4'd0 : pos_q + 4'd1;
        end
      end
      if (cmd_i.add_count) begin
        fin_q <= fin_i;
        if (cmd_i.load_chain) begin
          cnt_lo_q <= {56'd0, bytes_i};
          cnt_hi_q <= '0;
        end else begin
          cnt_lo_q <= sum_lo;
          if (sum_lo < {56'd0, bytes_i}) cnt_hi_q <= cnt_hi_q + 64'd1;
        end
      end else if (cmd_i.load_chain) begin
        cnt_lo_q <= '0;
        cnt_hi_q <= '0;
      end
      if (cmd_i.init_work) begin
        for (int i = 0; i < 8; i++) begin
          v_q[i] <= chain_q[i];
          v_q[i+8] <= b2b_pkg::iv(3'(i));
        end
        v_q[12] <= b2b_pkg::iv(3'd4) ^ cnt_lo_q;
        v_q[13] <= b2b_pkg::iv(3'd5) ^ cnt_hi_q;
        v_q[14] <= fin_q ? ~b2b_pkg::iv(3'd6) : b2b_pkg::iv(3'd6);
      end
      if (cmd_i.mix_step) begin
        for (int i = 0; i < 16; i++) v_q[i] <= v_d[i];
      end
      if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] ^ v_q[i] ^ v_q[i+8];
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/b2b_ctrl.sv
// Controller: input handshake, compression sequencing and digest output.
`default_nettype none
module b2b_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic start_i,
  input  wire logic end_i,
  input  wire logic fin_i,
  output b2b_pkg::b2b_cmd_t cmd_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic [2:0] out_idx_o
);
  typedef enum logic [2:0] {StIdle, StInit, StMix, StFold, StOut} state_e;
  state_e state_q;
  logic [b2b_pkg::RndW-1:0] rnd_q;
  logic diag_q, fin_q;
  logic [2:0] idx_q;
  logic acc;

  assign in_ready_o = (state_q == StIdle);
  assign acc = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == StOut);
  assign out_idx_o = idx_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.round = rnd_q;
    cmd_o.diag = diag_q;
    cmd_o.store_word = acc;
    cmd_o.load_chain = acc && start_i;
    cmd_o.add_count = acc && end_i;
    cmd_o.init_work = (state_q == StInit);
    cmd_o.mix_step = (state_q == StMix);
    cmd_o.fold = (state_q == StFold);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rnd_q <= '0;
      diag_q <= 1'b0;
      fin_q <= 1'b0;
      idx_q <= '0;
    end else begin
      unique case (state_q)
        StIdle: if (acc && end_i) begin
          fin_q <= fin_i;
          state_q <= StInit;
        end
        StInit: begin
          rnd_q <= '0;
          diag_q <= 1'b0;
          state_q <= StMix;
        end
        StMix: begin
          diag_q <= ~diag_q;
          if (diag_q) begin
            rnd_q <= rnd_q + b2b_pkg::RndW'(1);
            if (rnd_q == b2b_pkg::RndW'(b2b_pkg::Rounds - 1)) state_q <= StFold;
          end
        end
        StFold: begin
          idx_q <= '0;
          state_q <= fin_q ? StOut : StIdle;
        end
        StOut: if (out_ready_i) begin
          idx_q <= idx_q + 3'd1;
          if (idx_q == 3'd7) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire
